/* src/cnq_pkg.sv */
package cnq_pkg;

    localparam int PERSON_W  = 6;
    localparam int COUNT_W   = 7;
    localparam int OUTCOME_W = 2;
    localparam int PERSON_SPAN = 1 << PERSON_W;

    // register indexes
    localparam int REG_PEOPLE_COUNT = 0;
    localparam logic [COUNT_W-1:0] PEOPLE_COUNT_RESET = 7'd64;

    // item kinds carried on s_tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // result codes
    localparam logic [OUTCOME_W-1:0] OUT_DIRECT = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_VIA    = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_NONE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_QUERY_B,
        ST_QUERY_EVAL
    } state_t;

    typedef enum logic {
        RD_IN_A,
        RD_B
    } rd_sel_t;

    typedef enum logic {
        WR_ROW_A,
        WR_ROW_B
    } wr_sel_t;

    typedef struct packed {
        logic    take;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cap_row_a;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic pair_ok;
        logic same_person;
        logic out_free;
    } sts_t;

endpackage

/* src/cnq_ram.sv */
module cnq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/cnq_ctrl.sv */
module cnq_ctrl
    import cnq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    input  logic s_tuser,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.take   = s_tvalid;
                cmd.rd_en  = s_tvalid;
                cmd.rd_sel = RD_IN_A;
                if (s_tvalid)
                begin
                    state_next = (s_tuser == FUNC_QUERY) ? ST_QUERY_B : ST_LOAD_A;
                end
            end
            ST_LOAD_A:
            begin
                // if in range, write row a and fetch row b unless it is the same row
                cmd.wr_en  = sts.pair_ok;
                cmd.wr_sel = WR_ROW_A;
                cmd.rd_en  = sts.pair_ok && !sts.same_person;
                cmd.rd_sel = RD_B;
                state_next = (sts.pair_ok && !sts.same_person) ? ST_LOAD_B : ST_IDLE;
            end
            ST_LOAD_B:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_ROW_B;
                state_next = ST_IDLE;
            end
            ST_QUERY_B:
            begin
                cmd.cap_row_a = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RD_B;
                state_next    = ST_QUERY_EVAL;
            end
            ST_QUERY_EVAL:
            begin
                // hold until the output register can take the word
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/cnq_dpath.sv */
module cnq_dpath
    import cnq_pkg::*;
#(
    parameter int NUM_ROWS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [PERSON_W-1:0]  in_person_a,
    input  logic [PERSON_W-1:0]  in_person_b,
    input  logic                 in_contact_bit,
    input  logic [COUNT_W-1:0]   people_count,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUTCOME_W-1:0] outcome,
    output logic [PERSON_W-1:0]  via_person
);

    localparam int ADDR_W = $clog2(NUM_ROWS);
    localparam logic [COUNT_W-1:0] ROW_LIMIT = COUNT_W'(NUM_ROWS);

    function automatic logic in_range(input logic [PERSON_W-1:0] p);
        return {1'b0, p} < ROW_LIMIT;
    endfunction

    logic [PERSON_W-1:0]  a_reg;
    logic [PERSON_W-1:0]  b_reg;
    logic                 bit_reg;
    logic [NUM_ROWS-1:0]  row_valid_reg;
    logic                 rd_ok_reg;
    logic [NUM_ROWS-1:0]  row_a_reg;
    logic                 m_tvalid_reg;
    logic [OUTCOME_W-1:0] outcome_reg;
    logic [PERSON_W-1:0]  via_reg;

    logic [PERSON_W-1:0]  rd_person;
    logic [ADDR_W-1:0]    rd_idx;
    logic [PERSON_W-1:0]  wr_row_person;
    logic [PERSON_W-1:0]  wr_col_person;
    logic [ADDR_W-1:0]    wr_idx;
    logic [NUM_ROWS-1:0]  ram_q;
    logic [NUM_ROWS-1:0]  q_row;
    logic [NUM_ROWS-1:0]  wr_row;
    logic [NUM_ROWS-1:0]  search_mask;
    logic [NUM_ROWS-1:0]  hits;
    logic                 direct;
    logic                 found;
    logic [PERSON_W-1:0]  found_idx;
    logic [OUTCOME_W-1:0] outcome_next;
    logic [PERSON_W-1:0]  via_next;

    // read address: incoming person a in idle, latched person b later
    assign rd_person = (cmd.rd_sel == RD_IN_A) ? in_person_a : b_reg;
    assign rd_idx    = rd_person[ADDR_W-1:0];

    assign wr_row_person = (cmd.wr_sel == WR_ROW_A) ? a_reg : b_reg;
    assign wr_col_person = (cmd.wr_sel == WR_ROW_A) ? b_reg : a_reg;
    assign wr_idx        = wr_row_person[ADDR_W-1:0];

    // never-written or out-of-range rows read as zero
    assign q_row = rd_ok_reg ? ram_q : '0;

    always_comb
    begin
        wr_row = q_row;
        wr_row[wr_col_person[ADDR_W-1:0]] = bit_reg;
    end

    cnq_ram #(
        .WIDTH (NUM_ROWS),
        .DEPTH (NUM_ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_idx),
        .wdata (wr_row),
        .re    (cmd.rd_en),
        .raddr (rd_idx),
        .rdata (ram_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            a_reg   <= in_person_a;
            b_reg   <= in_person_b;
            bit_reg <= in_contact_bit;
        end
        if (cmd.cap_row_a)
        begin
            row_a_reg <= q_row;
        end
        if (cmd.load_out)
        begin
            outcome_reg <= outcome_next;
            via_reg     <= via_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                rd_ok_reg <= in_range(rd_person) && row_valid_reg[rd_idx];
            end
            if (cmd.wr_en)
            begin
                row_valid_reg[wr_idx] <= 1'b1;
            end
            if (cmd.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // search covers persons below the count in use
    always_comb
    begin
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            search_mask[i] = COUNT_W'(i) < people_count;
        end
    end

    assign hits   = row_a_reg & q_row & search_mask;
    assign direct = in_range(b_reg) && row_a_reg[b_reg[ADDR_W-1:0]];

    // lowest set hit wins
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = NUM_ROWS - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                found     = 1'b1;
                found_idx = PERSON_W'(i);
            end
        end
    end

    always_comb
    begin
        if (direct)
        begin
            outcome_next = OUT_DIRECT;
            via_next     = '0;
        end
        else if (found)
        begin
            outcome_next = OUT_VIA;
            via_next     = found_idx;
        end
        else
        begin
            outcome_next = OUT_NONE;
            via_next     = '0;
        end
    end

    assign sts.pair_ok     = in_range(a_reg) && in_range(b_reg);
    assign sts.same_person = (a_reg == b_reg);
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid   = m_tvalid_reg;
    assign outcome    = outcome_reg;
    assign via_person = via_reg;

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> sts.pair_ok)
        else $error("matrix write with a person outside the matrix");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !cmd.load_out)
        else $error("pending result overwritten");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_tvalid_reg)
        else $error("loaded result not presented");

    a_no_rw_mix: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(cmd.wr_en || cmd.rd_en || cmd.take))
        else $error("result loaded while the matrix is busy");

endmodule

/* src/common_neighbor_query.sv */
// Sequence: a query word is accepted in idle; row a is read, then row b is read
//   while row a is captured, and the result is loaded into the output register;
//   a result still waiting on m_tready holds the query in evaluation. A load word
//   returns no result. Pacing: a new word is taken only back in idle, set by the
//   single read port of the matrix RAM, which gives one row per cycle, and a query
//   or a load needs rows a and b (a load of one person with himself only row a).
// Reset: row valid flags clear at once so the whole matrix reads as zero;
//   people_count returns to 64; no clearing pass is run.
module common_neighbor_query
    import cnq_pkg::*;
#(
    parameter int MAX_PEOPLE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] person_a, [11:6] person_b, [12] contact_bit
    input  logic        s_tuser,   // [0] func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] outcome, [7:2] via_person
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // persons are addressed by 6-bit fields, so rows beyond 64 can never be set
    localparam int NUM_ROWS = (MAX_PEOPLE < PERSON_SPAN) ? MAX_PEOPLE : PERSON_SPAN;

    logic [COUNT_W-1:0]   people_count_reg;
    logic                 reg_sel;
    cmd_t                 cmd;
    sts_t                 sts;
    logic [OUTCOME_W-1:0] outcome;
    logic [PERSON_W-1:0]  via_person;

    // register decode by word address; byte lanes within a word are ignored
    assign reg_sel = (paddr[2] == 1'(REG_PEOPLE_COUNT));
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(32 - COUNT_W){1'b0}}, people_count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            people_count_reg <= PEOPLE_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            people_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // sequencer: decides which row is read or written each cycle
    cnq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // matrix storage, search logic and output register
    cnq_dpath #(
        .NUM_ROWS (NUM_ROWS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_person_a    (s_tdata[5:0]),
        .in_person_b    (s_tdata[11:6]),
        .in_contact_bit (s_tdata[12]),
        .people_count   (people_count_reg),
        .cmd            (cmd),
        .sts            (sts),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .outcome        (outcome),
        .via_person     (via_person)
    );

    assign m_tdata = {via_person, outcome};

endmodule

/* dv/testbench.sv */
module testbench;
    import cnq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PEOPLE  = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;   // lets trailing load words finish

    // one input word as the block sees it
    typedef struct packed {
        logic                func;
        logic [PERSON_W-1:0] person_a;
        logic [PERSON_W-1:0] person_b;
        logic                contact_bit;
    } contact_word_t;

    // one result word
    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [PERSON_W-1:0]  via_person;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [5:0] person_a, [11:6] person_b, [12] contact_bit
    logic        s_tuser = 1'b0; // [0] func

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [1:0] outcome, [7:2] via_person

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    common_neighbor_query #(
        .MAX_PEOPLE (MAX_PEOPLE)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow state of the block: the symmetric contact matrix and the
    // count in use. Only touched at accepted words and register writes.
    // ------------------------------------------------------------------
    logic [MAX_PEOPLE-1:0] contact_rows [MAX_PEOPLE];
    logic [COUNT_W-1:0]    people_in_use;

    contact_word_t pending_words [$];    // words waiting for the driver
    answer_t       expected_answers [$]; // answers owed by the block, oldest first

    int cycle_count    = 0;
    int mismatch_count = 0;
    int words_taken    = 0;
    int loads_taken    = 0;
    int answers_seen   = 0;
    int settings_written = 0;
    int outcome_tally [3] = '{0, 0, 0};

    // Work out the answer to a query from the shadow matrix: direct contact
    // first, then the lowest common contact below the count in use.
    function automatic answer_t answer_query(input logic [PERSON_W-1:0] pa,
                                             input logic [PERSON_W-1:0] pb);
        answer_t ans;
        int      span;
        ans.outcome    = OUT_NONE;
        ans.via_person = '0;
        if (contact_rows[pa][pb]) begin
            ans.outcome = OUT_DIRECT;
            return ans;
        end
        // count above the matrix size stops at the matrix size; zero searches nobody
        span = (int'(people_in_use) > MAX_PEOPLE) ? MAX_PEOPLE : int'(people_in_use);
        for (int i = 0; i < span; i++) begin
            if (contact_rows[pa][i] && contact_rows[pb][i]) begin
                ans.outcome    = OUT_VIA;
                ans.via_person = i[PERSON_W-1:0];
                return ans;
            end
        end
        return ans;
    endfunction

    // Advance the shadow state by one accepted word.
    task automatic track_word(input contact_word_t w);
        answer_t ans;
        words_taken++;
        if (w.func == FUNC_LOAD) begin
            contact_rows[w.person_a][w.person_b] = w.contact_bit;
            contact_rows[w.person_b][w.person_a] = w.contact_bit;
            loads_taken++;
        end else begin
            ans = answer_query(w.person_a, w.person_b);
            expected_answers.push_back(ans);
            outcome_tally[ans.outcome]++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present pending words in bursts of random length separated
    // by random gaps. Hold a word until it is taken.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk) begin : drive_words
        contact_word_t w;
        contact_word_t taken;
        logic          next_valid;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                // sample the word as it stood before this edge
                taken.func        = s_tuser;
                taken.person_a    = s_tdata[5:0];
                taken.person_b    = s_tdata[11:6];
                taken.contact_bit = s_tdata[12];
                track_word(taken);
            end
            // a word still waiting for ready stays put
            if (!(s_tvalid && !s_tready)) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    next_valid = 1'b1;
                    s_tdata  <= {3'b000, w.contact_bit, w.person_b, w.person_a};
                    s_tuser  <= w.func;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // end of burst: pick the next burst and the gap ahead of it
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                s_tvalid <= next_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: a mode is drawn for each stretch of random length:
    // always ready, coin flip, a rotating pattern, or long stalls.
    // ------------------------------------------------------------------
    int          stall_mode    = 0;
    int          stall_left    = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          stall_phase   = 0;

    always @(posedge clk) begin : pace_results
        logic ready;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode    = $urandom_range(0, 3);
                stall_left    = $urandom_range(16, 80);
                stall_pattern = 16'($urandom) | 16'h0001;
            end else begin
                stall_left--;
            end
            stall_phase = (stall_phase + 1) % 16;
            case (stall_mode)
                0:       ready = 1'b1;
                1:       ready = 1'($urandom_range(0, 1));
                2:       ready = stall_pattern[stall_phase];
                default: ready = ($urandom_range(0, 7) == 0);
            endcase
            m_tready <= ready;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken result word with the oldest answer owed.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_answers
        answer_t want;
        answer_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.outcome    = m_tdata[1:0];
            got.via_person = m_tdata[7:2];
            answers_seen++;
            if (expected_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] unexpected result word: outcome %0d via %0d",
                             $realtime, got.outcome, got.via_person);
            end else begin
                want = expected_answers.pop_front();
                if (got.outcome !== want.outcome || got.via_person !== want.via_person) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] result mismatch: outcome %0d/%0d via %0d/%0d (exp/act)",
                                 $realtime, want.outcome, got.outcome,
                                 want.via_person, got.via_person);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers still owed",
                     cycle_count, expected_answers.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the count in use, mirror it, and read it back.
    task automatic set_people_count(input logic [COUNT_W-1:0] count);
        logic [31:0] readback;
        apb_write(3'(4 * REG_PEOPLE_COUNT), 32'(count));
        people_in_use = count;
        settings_written++;
        apb_read(3'(4 * REG_PEOPLE_COUNT), readback);
        if (readback[COUNT_W-1:0] !== count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] people_count readback mismatch: exp %0d act %0d",
                         $realtime, count, readback[COUNT_W-1:0]);
        end
    endtask

    task automatic queue_word(input logic func, input int pa, input int pb, input logic cbit);
        contact_word_t w;
        w.func        = func;
        w.person_a    = pa[PERSON_W-1:0];
        w.person_b    = pb[PERSON_W-1:0];
        w.contact_bit = cbit;
        pending_words.push_back(w);
    endtask

    // Drop all pending stimulus through the block, collect every answer,
    // then let trailing load words finish.
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Draw a person: mostly from a narrow window so that contacts overlap
    // and common-contact answers come up, sometimes the extremes, else anyone.
    function automatic int pick_person(input int window_base);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return window_base + $urandom_range(0, 7);
        if (roll < 75)
            return ($urandom_range(0, 1) != 0) ? MAX_PEOPLE - 1 : 0;
        return $urandom_range(0, MAX_PEOPLE - 1);
    endfunction

    initial begin : run_test
        int count_plan [8];
        int window_base;
        int pa;
        int pb;
        logic is_load;

        for (int r = 0; r < MAX_PEOPLE; r++)
            contact_rows[r] = '0;
        people_in_use = PEOPLE_COUNT_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed words at the reset count: empty matrix, diagonal,
        // lowest common contact, symmetry, clearing a bit, same person twice.
        queue_word(FUNC_QUERY, 0, 0, 1'b0);     // empty matrix: no contact
        queue_word(FUNC_QUERY, 63, 0, 1'b1);
        queue_word(FUNC_LOAD, 63, 63, 1'b1);    // diagonal bit
        queue_word(FUNC_QUERY, 63, 63, 1'b0);   // direct through the diagonal
        queue_word(FUNC_LOAD, 0, 5, 1'b1);
        queue_word(FUNC_LOAD, 63, 5, 1'b1);
        queue_word(FUNC_QUERY, 0, 63, 1'b0);    // through person 5
        queue_word(FUNC_LOAD, 2, 0, 1'b1);
        queue_word(FUNC_LOAD, 2, 63, 1'b1);
        queue_word(FUNC_QUERY, 63, 0, 1'b0);    // lowest common contact wins: 2
        queue_word(FUNC_LOAD, 0, 63, 1'b1);
        queue_word(FUNC_QUERY, 0, 63, 1'b0);    // direct now
        queue_word(FUNC_LOAD, 63, 0, 1'b0);     // clear through the mirrored entry
        queue_word(FUNC_QUERY, 0, 63, 1'b0);    // back to through 2
        queue_word(FUNC_QUERY, 5, 5, 1'b0);     // same person, diagonal clear: via 0
        queue_word(FUNC_LOAD, 62, 63, 1'b1);
        queue_word(FUNC_QUERY, 62, 62, 1'b0);   // same person: search finds 63
        queue_word(FUNC_LOAD, 1, 1, 1'b1);
        queue_word(FUNC_QUERY, 1, 1, 1'b0);
        queue_word(FUNC_QUERY, 1, 2, 1'b0);     // no shared contact
        wait_idle();

        // Random phases under a range of counts in use, including
        // zero, one, the matrix size and values past it.
        count_plan = '{64, 1, 0, 127, 65, 2, 33, 64};
        count_plan[5] = $urandom_range(2, 63);
        for (int ph = 0; ph < 8; ph++) begin
            set_people_count(count_plan[ph][COUNT_W-1:0]);
            window_base = (ph % 2 == 1) ? 0 : $urandom_range(0, MAX_PEOPLE - 8);
            for (int n = 0; n < 82; n++) begin
                is_load = ($urandom_range(0, 99) < 55);
                pa = pick_person(window_base);
                pb = ($urandom_range(0, 19) == 0) ? pa : pick_person(window_base);
                queue_word(is_load ? FUNC_LOAD : FUNC_QUERY, pa, pb,
                           1'($urandom_range(0, 9) < 7));
            end
            wait_idle();
        end

        $display("covered %0d words (%0d loads) over %0d count settings",
                 words_taken, loads_taken, settings_written);
        $display("answers checked %0d: direct %0d, through a person %0d, none %0d",
                 answers_seen, outcome_tally[OUT_DIRECT], outcome_tally[OUT_VIA],
                 outcome_tally[OUT_NONE]);
        if (mismatch_count == 0 && expected_answers.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d answers never arrived",
                     mismatch_count, expected_answers.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
